FILE: rtl/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants for the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int MAX_SEGS_DEF   = 16;
  localparam int ADDR_W         = 16;
  localparam int OWNER_W        = 8;
  localparam int USED_W         = 5;
  localparam logic [ADDR_W-1:0] POOL_RESET = 16'd640;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_ID = 2'd1;
  localparam logic [1:0] ST_NO_FIT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic REG_FIT_MODE  = 1'b0;
  localparam logic REG_POOL_SIZE = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [ADDR_W-1:0]  size;
    logic [OWNER_W-1:0] owner;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_SPLIT = 2'd2,
    CELL_MERGE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   wa;
    entry_t   wb;
  } cell_cmd_t;

endpackage

FILE: rtl/vpa_cell.sv
// ----------------------------------------------------------------------------
// vpa_cell
// One segment table entry. Loads in place, or takes its neighbor's entry
// when the table opens a gap (split) or closes one (merge).
// ----------------------------------------------------------------------------
module vpa_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  logic               clk,
  input  vpa_pkg::cell_cmd_t cmd,
  input  logic [IW-1:0]      pos,
  input  vpa_pkg::entry_t    left,
  input  vpa_pkg::entry_t    right,
  output vpa_pkg::entry_t    q
);

  always_ff @(posedge clk) begin
    case (cmd.op)
      vpa_pkg::CELL_LOAD: begin
        if (IDX == int'(pos)) q <= cmd.wa;
      end
      vpa_pkg::CELL_SPLIT: begin
        if (IDX == int'(pos)) begin
          q <= cmd.wa;
        end else if (IDX == int'(pos) + 1) begin
          q <= cmd.wb;
        end else if (IDX > int'(pos) + 1) begin
          q <= left;
        end
      end
      vpa_pkg::CELL_MERGE: begin
        if (IDX == int'(pos)) begin
          q <= cmd.wa;
        end else if (IDX > int'(pos)) begin
          q <= right;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/variable_partition_allocator.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator
// Address-ordered segment table in a row of cells; first-fit or best-fit
// allocate, release with merge of free neighbors.
// ----------------------------------------------------------------------------
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tuser: opcode; tdata: job_id, req_size
// m_axis    out  tvalid/tready         tdata: status, start_address,
//                                             released, segments_used
// cfg       in   cfg_we                cfg_index, cfg_data
//
// Each word runs a scan of the cell row, one entry per cycle, then update and
// result; a release that merges with a free left neighbor adds a left-merge
// step (S_MRGL) between the update and the result.
// Reset (rst, synchronous) leaves one free segment [0, 640) in first fit.
// A new word is taken while a result waits on m_axis; the block holds its
// finished result until the output register frees up.
// ----------------------------------------------------------------------------
module variable_partition_allocator #(
  parameter int MAX_SEGS = vpa_pkg::MAX_SEGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] job_id, [23:8] req_size
  input  logic [0:0]  s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] status, [17:2] start_address,
                                      // [18] released, [23:19] segments_used
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
  localparam int CW = $clog2(MAX_SEGS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_APPLY = 5'b00100,
    S_MRGL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  vpa_pkg::entry_t   cell_q [MAX_SEGS];
  vpa_pkg::cell_cmd_t cmd;
  logic [IW-1:0]     cmd_pos;

  logic              fit_mode;
  logic [CW-1:0]     count;

  logic              opc;
  logic [7:0]        jid;
  logic [15:0]       rsize;
  logic [IW-1:0]     idx;

  vpa_pkg::entry_t   prev;
  logic              mfound;
  logic [IW-1:0]     midx;
  logic [15:0]       m_start;
  logic [15:0]       m_size;
  logic              lfree;
  logic [15:0]       l_start;
  logic [15:0]       l_size;
  logic              rchk;
  logic              rfree;
  logic [15:0]       r_size;
  logic              ffound;
  logic [IW-1:0]     pick;
  logic [15:0]       p_start;
  logic [15:0]       p_size;

  logic [1:0]        res_status;
  logic [15:0]       res_addr;
  logic              res_rel;

  logic              out_valid;
  logic [23:0]       out_data;

  vpa_pkg::entry_t   e;
  logic              scan_last;
  logic              out_free;

  assign e         = cell_q[idx];
  assign scan_last = (CW'(idx) + CW'(1)) == count;
  assign out_free  = !out_valid || m_axis_tready;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // cell row
  for (genvar g = 0; g < MAX_SEGS; g++) begin : g_cell
    vpa_pkg::entry_t lft;
    vpa_pkg::entry_t rgt;
    if (g == 0) begin : g_head
      assign lft = cell_q[0];
    end else begin : g_mid
      assign lft = cell_q[g-1];
    end
    if (g == MAX_SEGS - 1) begin : g_tail
      assign rgt = cell_q[g];
    end else begin : g_body
      assign rgt = cell_q[g+1];
    end
    vpa_cell #(.IDX(g), .IW(IW)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .pos   (cmd_pos),
      .left  (lft),
      .right (rgt),
      .q     (cell_q[g])
    );
  end

  // cell commands
  always_comb begin
    cmd.op  = vpa_pkg::CELL_HOLD;
    cmd.wa  = '0;
    cmd.wb  = '0;
    cmd_pos = '0;
    if (rst) begin
      cmd.op      = vpa_pkg::CELL_LOAD;
      cmd.wa.size = vpa_pkg::POOL_RESET;
    end else if (cfg_we && cfg_index == vpa_pkg::REG_POOL_SIZE) begin
      cmd.op      = vpa_pkg::CELL_LOAD;
      cmd.wa.size = cfg_data;
    end else begin
      case (state)
        S_APPLY: begin
          if (opc == vpa_pkg::OP_ALLOC) begin
            if (jid != '0 && !mfound && rsize != '0 && ffound) begin
              cmd_pos = pick;
              if (p_size == rsize) begin
                cmd.op = vpa_pkg::CELL_LOAD;
                cmd.wa = '{start: p_start, size: p_size, owner: jid};
              end else if (count != CW'(MAX_SEGS)) begin
                cmd.op = vpa_pkg::CELL_SPLIT;
                cmd.wa = '{start: p_start, size: rsize, owner: jid};
                cmd.wb = '{start: p_start + rsize, size: p_size - rsize, owner: '0};
              end
            end
          end else if (jid != '0 && mfound) begin
            cmd_pos = midx;
            if (rfree) begin
              cmd.op = vpa_pkg::CELL_MERGE;
              cmd.wa = '{start: m_start, size: m_size + r_size, owner: '0};
            end else begin
              cmd.op = vpa_pkg::CELL_LOAD;
              cmd.wa = '{start: m_start, size: m_size, owner: '0};
            end
          end
        end
        S_MRGL: begin
          cmd_pos = midx - IW'(1);
          cmd.op  = vpa_pkg::CELL_MERGE;
          cmd.wa  = '{start: l_start, size: l_size + m_size, owner: '0};
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fit_mode  <= 1'b0;
      count     <= CW'(1);
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        if (cfg_index == vpa_pkg::REG_FIT_MODE) begin
          fit_mode <= cfg_data[0];
        end else begin
          count <= CW'(1);
        end
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            opc        <= s_axis_tuser[0];
            jid        <= s_axis_tdata[7:0];
            rsize      <= s_axis_tdata[23:8];
            idx        <= '0;
            mfound     <= 1'b0;
            ffound     <= 1'b0;
            lfree      <= 1'b0;
            rchk       <= 1'b0;
            rfree      <= 1'b0;
            res_status <= vpa_pkg::ST_OK;
            res_addr   <= '0;
            res_rel    <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rchk) begin
            rfree  <= (e.owner == '0);
            r_size <= e.size;
            rchk   <= 1'b0;
          end
          if (!mfound && e.owner == jid) begin
            mfound  <= 1'b1;
            midx    <= idx;
            m_start <= e.start;
            m_size  <= e.size;
            lfree   <= (idx != '0) && (prev.owner == '0);
            l_start <= prev.start;
            l_size  <= prev.size;
            rchk    <= 1'b1;
          end
          if (e.owner == '0 && e.size >= rsize &&
              (!ffound || (fit_mode && e.size < p_size))) begin
            ffound  <= 1'b1;
            pick    <= idx;
            p_start <= e.start;
            p_size  <= e.size;
          end
          prev <= e;
          if (scan_last) begin
            state <= S_APPLY;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_APPLY: begin
          state <= (opc == vpa_pkg::OP_RELEASE && jid != '0 && mfound && lfree) ?
                   S_MRGL : S_DONE;
          if (opc == vpa_pkg::OP_ALLOC) begin
            if (jid == '0 || mfound) begin
              res_status <= vpa_pkg::ST_BAD_ID;
            end else if (rsize == '0 || !ffound) begin
              res_status <= vpa_pkg::ST_NO_FIT;
            end else if (p_size == rsize) begin
              res_addr <= p_start;
            end else if (count == CW'(MAX_SEGS)) begin
              res_status <= vpa_pkg::ST_FULL;
            end else begin
              res_addr <= p_start;
              count    <= count + CW'(1);
            end
          end else if (jid != '0 && mfound) begin
            res_rel <= 1'b1;
            if (rfree) begin
              m_size <= m_size + r_size;
              count  <= count - CW'(1);
            end
          end
        end
        S_MRGL: begin
          count <= count - CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_data  <= {vpa_pkg::USED_W'(count), res_rel, res_addr, res_status};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/variable_partition_allocator_tb.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator_tb
// Self-checking bench for the segment allocator. Requests stream in on s_axis
// and a local copy of the segment table predicts every reply. Replies on
// m_axis are checked field by field in order. Directed requests come first:
// bad ids, zero size, exact fit, release merges, a zero pool and a full
// table. Random phases follow, with both fit modes, several pool sizes,
// random gaps on either side and one long receiver hold-off.
// ----------------------------------------------------------------------------
module variable_partition_allocator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH    = vpa_pkg::MAX_SEGS_DEF;
  localparam int DRAIN_CYCLES   = 32;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 40;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] start_address;
    logic        released;
    logic [4:0]  segments_used;
  } alloc_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [7:0] job_id, [23:8] req_size
  logic [0:0]  s_axis_tuser = '0;   // [0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [1:0] status, [17:2] start_address,
                                    // [18] released, [23:19] segments_used
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  // predicted segment table
  logic [15:0] part_base [TABLE_DEPTH];
  logic [15:0] part_len  [TABLE_DEPTH];
  logic [7:0]  part_job  [TABLE_DEPTH];
  int          part_count;
  logic        pick_smallest;
  logic [15:0] pool_units;

  alloc_reply_t pending_replies [$];
  int err_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  variable_partition_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic void reset_table();
    part_count   = 1;
    part_base[0] = '0;
    part_len[0]  = pool_units;
    part_job[0]  = '0;
  endfunction

  function automatic int find_job(logic [7:0] job);
    for (int k = 0; k < part_count; k++) begin
      if (part_job[k] == job) return k;
    end
    return -1;
  endfunction

  function automatic void drop_entry(int idx);
    for (int k = idx; k + 1 < part_count; k++) begin
      part_base[k] = part_base[k+1];
      part_len[k]  = part_len[k+1];
      part_job[k]  = part_job[k+1];
    end
    part_count--;
  endfunction

  // updates the predicted table and returns the reply the block must give
  function automatic alloc_reply_t apply_request(logic op, logic [7:0] job,
                                                 logic [15:0] units);
    alloc_reply_t r;
    int pick;
    int k;
    bit found;
    r = '0;
    pick = 0;
    found = 1'b0;
    if (op == vpa_pkg::OP_RELEASE) begin
      k = (job == 0) ? -1 : find_job(job);
      if (k >= 0) begin
        r.released = 1'b1;
        part_job[k] = '0;
        if (k + 1 < part_count && part_job[k+1] == 0) begin
          part_len[k] = part_len[k] + part_len[k+1];
          drop_entry(k + 1);
        end
        if (k > 0 && part_job[k-1] == 0) begin
          part_len[k-1] = part_len[k-1] + part_len[k];
          drop_entry(k);
        end
      end
    end else if (job == 0 || find_job(job) >= 0) begin
      r.status = vpa_pkg::ST_BAD_ID;
    end else if (units == 0) begin
      r.status = vpa_pkg::ST_NO_FIT;
    end else begin
      for (k = 0; k < part_count; k++) begin
        if (part_job[k] == 0 && part_len[k] >= units &&
            (!found || (pick_smallest && part_len[k] < part_len[pick]))) begin
          pick = k;
          found = 1'b1;
          if (!pick_smallest) break;
        end
      end
      if (!found) begin
        r.status = vpa_pkg::ST_NO_FIT;
      end else if (part_len[pick] == units) begin
        part_job[pick] = job;
        r.start_address = part_base[pick];
      end else if (part_count >= TABLE_DEPTH) begin
        r.status = vpa_pkg::ST_FULL;
      end else begin
        for (k = part_count; k > pick; k--) begin
          part_base[k] = part_base[k-1];
          part_len[k]  = part_len[k-1];
          part_job[k]  = part_job[k-1];
        end
        part_count++;
        part_len[pick]    = units;
        part_job[pick]    = job;
        part_base[pick+1] = part_base[pick] + units;
        part_len[pick+1]  = part_len[pick+1] - units;
        part_job[pick+1]  = '0;
        r.start_address   = part_base[pick];
      end
    end
    r.segments_used = 5'(part_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic send_word(input logic op, input logic [7:0] job,
                           input logic [15:0] units);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {units, job};
    do @(posedge clk); while (!s_axis_tready);
    pending_replies.push_back(apply_request(op, job, units));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == vpa_pkg::REG_FIT_MODE) begin
      pick_smallest = val[0];
    end else begin
      pool_units = val;
      reset_table();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_phase(input logic mode, input logic [15:0] pool,
                           input int sidle, input int rstall);
    wait_idle();
    write_reg(vpa_pkg::REG_FIT_MODE, {15'd0, mode});
    write_reg(vpa_pkg::REG_POOL_SIZE, pool);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
  endtask

  // mostly fresh allocations and releases of owned jobs, some noise
  task automatic send_random(input int n);
    logic        op;
    logic [7:0]  job;
    logic [15:0] units;
    int k;
    int roll;
    int cap;
    for (int i = 0; i < n; i++) begin
      cap = (pool_units / 10 > 1) ? pool_units / 10 : 1;
      roll = $urandom_range(0, 99);
      units = 16'($urandom_range(0, 65535));
      k = $urandom_range(0, part_count - 1);
      if (roll < 45) begin
        op = vpa_pkg::OP_ALLOC;
        do job = 8'($urandom_range(1, 255)); while (find_job(job) >= 0);
        case ($urandom_range(0, 9))
          0: units = (part_job[k] == 0) ? part_len[k] : 16'd1;
          1: units = 16'($urandom_range(1, 65535));
          default: units = 16'($urandom_range(1, cap));
        endcase
      end else if (roll < 80) begin
        op = vpa_pkg::OP_RELEASE;
        job = 8'($urandom_range(1, 255));
        for (int j = 0; j < part_count; j++) begin
          if (part_job[(k + j) % part_count] != 0) begin
            job = part_job[(k + j) % part_count];
            break;
          end
        end
      end else begin
        op = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 2))
          0: job = '0;
          1: job = part_job[k];
          default: job = 8'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 3) == 0) units = '0;
      end
      send_word(op, job, units);
    end
  endtask

  task automatic test_directed_requests();
    set_phase(1'b0, vpa_pkg::POOL_RESET, 0, 0);
    send_word(vpa_pkg::OP_ALLOC, 8'd0, 16'd10);
    send_word(vpa_pkg::OP_ALLOC, 8'd1, 16'd0);
    send_word(vpa_pkg::OP_ALLOC, 8'd1, 16'hFFFF);
    send_word(vpa_pkg::OP_ALLOC, 8'd1, 16'd100);
    send_word(vpa_pkg::OP_ALLOC, 8'd1, 16'd5);
    send_word(vpa_pkg::OP_ALLOC, 8'd255, 16'd540);
    send_word(vpa_pkg::OP_RELEASE, 8'd0, 16'hFFFF);
    send_word(vpa_pkg::OP_RELEASE, 8'd1, 16'd0);
    send_word(vpa_pkg::OP_RELEASE, 8'd255, 16'hA5A5);
  endtask

  task automatic test_pool_extremes();
    set_phase(1'b1, 16'd0, 0, 0);
    send_word(vpa_pkg::OP_ALLOC, 8'd3, 16'd1);
    set_phase(1'b1, 16'hFFFF, 0, 0);
    send_word(vpa_pkg::OP_ALLOC, 8'd170, 16'hFFFF);
  endtask

  task automatic test_table_full();
    set_phase(1'b0, 16'd17, 0, 0);
    for (int j = 1; j < TABLE_DEPTH; j++) send_word(vpa_pkg::OP_ALLOC, 8'(j), 16'd1);
    send_word(vpa_pkg::OP_ALLOC, 8'd16, 16'd1);
    send_word(vpa_pkg::OP_ALLOC, 8'd16, 16'd2);
  endtask

  task automatic test_first_fit_streaming();
    set_phase(1'b0, vpa_pkg::POOL_RESET, 0, 0);
    send_random(300);
  endtask

  task automatic test_smallest_fit_sender_gaps();
    set_phase(1'b1, vpa_pkg::POOL_RESET, 60, 0);
    send_random(300);
  endtask

  task automatic test_large_pool_receiver_stalls();
    set_phase(1'b0, 16'hFFFF, 0, 60);
    send_random(300);
  endtask

  task automatic test_smallest_fit_both_idle();
    set_phase(1'b1, 16'($urandom_range(100, 4000)), 11, 11);
    send_random(300);
  endtask

  task automatic test_unit_pool();
    set_phase(1'b1, 16'd1, 11, 11);
    send_random(80);
  endtask

  task automatic test_backpressure();
    set_phase(1'b0, vpa_pkg::POOL_RESET, 0, 0);
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    send_random(150);
  endtask

  task automatic test_smallest_fit_large_pool();
    set_phase(1'b1, 16'hFFFF, 0, 0);
    send_random(270);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : reply_check
    alloc_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected reply %h", m_axis_tdata));
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tdata[1:0] != want.status)
          report_mismatch($sformatf("status %0d, want %0d",
                                    m_axis_tdata[1:0], want.status));
        if (m_axis_tdata[17:2] != want.start_address)
          report_mismatch($sformatf("start_address %0d, want %0d",
                                    m_axis_tdata[17:2], want.start_address));
        if (m_axis_tdata[18] != want.released)
          report_mismatch($sformatf("released %0d, want %0d",
                                    m_axis_tdata[18], want.released));
        if (m_axis_tdata[23:19] != want.segments_used)
          report_mismatch($sformatf("segments_used %0d, want %0d",
                                    m_axis_tdata[23:19], want.segments_used));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("[variable_partition_allocator] ERROR");
    $finish;
  end

  initial begin
    pick_smallest = 1'b0;
    pool_units    = vpa_pkg::POOL_RESET;
    reset_table();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_requests();
    test_pool_extremes();
    test_table_full();
    test_first_fit_streaming();
    test_smallest_fit_sender_gaps();
    test_large_pool_receiver_stalls();
    test_smallest_fit_both_idle();
    test_unit_pool();
    test_backpressure();
    test_smallest_fit_large_pool();

    wait_idle();
    if (err_cnt == 0)
      $display("[variable_partition_allocator] OK");
    else
      $display("[variable_partition_allocator] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/vpa_pkg.sv
rtl/vpa_cell.sv
rtl/variable_partition_allocator.sv
tb/variable_partition_allocator_tb.sv
